// File: rtl/core/adsr_db_pkg.sv
// Shared types and constants for the centibel ADSR envelope block.
`default_nettype none

package adsr_db_pkg;

    // Fixed-point format and counter width
    localparam int COUNT_WIDTH     = 24;
    localparam int FRAC_BITS       = 16;
    localparam int CB_WIDTH        = 10;
    localparam int LEVEL_WIDTH     = CB_WIDTH + FRAC_BITS;
    localparam int RATE_WIDTH      = 26;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 26;

    // Envelope limits
    localparam int FULL_CB    = 960;
    localparam int MIN_ATTACK = 12;
    localparam logic [CB_WIDTH-1:0]    FULL_CB_VAL = CB_WIDTH'(FULL_CB);
    localparam logic [LEVEL_WIDTH-1:0] MAX_LEVEL   = {FULL_CB_VAL, {FRAC_BITS{1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ATTACK_STEPS  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ATTACK_RATE   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DECAY_STEPS   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DECAY_RATE    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUSTAIN_LEVEL = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_STEPS = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_RATE  = 3'd6;

    // Envelope phases
    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    // Configuration register file contents
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] attack_steps;
        logic [RATE_WIDTH-1:0]  attack_rate;
        logic [COUNT_WIDTH-1:0] decay_len;
        logic [RATE_WIDTH-1:0]  decay_inc;
        logic [CB_WIDTH-1:0]    sustain_level;
        logic [COUNT_WIDTH-1:0] release_len;
        logic [RATE_WIDTH-1:0]  release_inc;
    } t_cfg;

    // Envelope state carried from tick to tick
    typedef struct packed {
        t_phase                 phase;
        logic [COUNT_WIDTH-1:0] count;
        logic [LEVEL_WIDTH-1:0] level;
    } t_env_state;

    // Channel payloads
    typedef struct packed {
        logic note_on;
        logic note_off;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] attenuation;
        logic [2:0]             phase;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/adsr_db_cfg.sv
// Configuration register file for the envelope.
`default_nettype none

module adsr_db_cfg
    import adsr_db_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_cfg                            o_cfg
);

    t_cfg r_cfg;

    // Decode the index and store the write, truncated to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ATTACK_STEPS:  r_cfg.attack_steps  <= i_cfg_data[COUNT_WIDTH-1:0];
                CFG_ATTACK_RATE:   r_cfg.attack_rate   <= i_cfg_data[RATE_WIDTH-1:0];
                CFG_DECAY_STEPS:   r_cfg.decay_len     <= i_cfg_data[COUNT_WIDTH-1:0];
                CFG_DECAY_RATE:    r_cfg.decay_inc     <= i_cfg_data[RATE_WIDTH-1:0];
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_data[CB_WIDTH-1:0];
                CFG_RELEASE_STEPS: r_cfg.release_len   <= i_cfg_data[COUNT_WIDTH-1:0];
                CFG_RELEASE_RATE:  r_cfg.release_inc   <= i_cfg_data[RATE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/adsr_db_step.sv
// One-tick envelope update: note handling, phase sequencing and level arithmetic.
`default_nettype none

module adsr_db_step
    import adsr_db_pkg::*;
(
    input  wire t_cfg       i_cfg,
    input  wire t_env_state i_state,
    input  wire t_in_item   i_item,
    output t_env_state      o_state
);

    t_env_state             s_entry;
    logic [COUNT_WIDTH-1:0] s_limit;
    logic                   s_active;
    logic                   s_run;
    logic [COUNT_WIDTH-1:0] s_count_step;
    logic                   s_phase_end;
    logic [CB_WIDTH-1:0]    s_sustain_sat;
    logic [LEVEL_WIDTH-1:0] s_target;
    logic [LEVEL_WIDTH:0]   s_sum_decay;
    logic [LEVEL_WIDTH:0]   s_sum_release;
    logic [LEVEL_WIDTH-1:0] n_level;
    t_phase                 n_phase;

    // Apply note-on first, then note-off
    always_comb begin
        s_entry = i_state;
        if (i_item.note_on) begin
            s_entry.count = '0;
            if (i_cfg.attack_steps < COUNT_WIDTH'(MIN_ATTACK)) begin
                s_entry.level = '0;
                s_entry.phase = PH_DECAY;
            end else begin
                s_entry.level = MAX_LEVEL;
                s_entry.phase = PH_ATTACK;
            end
        end
        if (i_item.note_off) begin
            s_entry.phase = PH_RELEASE;
            s_entry.count = '0;
        end
    end

    // Pick the step limit of the timed phases and advance the tick counter
    always_comb begin
        unique case (s_entry.phase)
            PH_ATTACK: begin
                s_limit  = i_cfg.attack_steps;
                s_active = 1'b1;
            end
            PH_DECAY: begin
                s_limit  = i_cfg.decay_len;
                s_active = 1'b1;
            end
            PH_RELEASE: begin
                s_limit  = i_cfg.release_len;
                s_active = 1'b1;
            end
            default: begin
                s_limit  = '0;
                s_active = 1'b0;
            end
        endcase
        s_run        = s_active && (s_entry.count < s_limit);
        s_count_step = s_run ? s_entry.count + COUNT_WIDTH'(1) : s_entry.count;
        s_phase_end  = s_active && (s_count_step >= s_limit);
    end

    // Saturate the sustain level to full scale
    assign s_sustain_sat = (i_cfg.sustain_level > FULL_CB_VAL) ? FULL_CB_VAL
                                                                : i_cfg.sustain_level;
    assign s_target      = {s_sustain_sat, {FRAC_BITS{1'b0}}};
    assign s_sum_decay   = {1'b0, s_entry.level} + {1'b0, i_cfg.decay_inc};
    assign s_sum_release = {1'b0, s_entry.level} + {1'b0, i_cfg.release_inc};

    // Move the level by the phase's rate, saturating at the phase's bound
    always_comb begin
        n_level = s_entry.level;
        if (s_run) begin
            case (s_entry.phase)
                PH_ATTACK: begin
                    n_level = (i_cfg.attack_rate >= s_entry.level) ? '0
                            : s_entry.level - i_cfg.attack_rate;
                end
                PH_DECAY: begin
                    if (s_entry.level < s_target) begin
                        n_level = (s_sum_decay >= {1'b0, s_target}) ? s_target
                                : s_sum_decay[LEVEL_WIDTH-1:0];
                    end
                end
                PH_RELEASE: begin
                    if (s_entry.level >= MAX_LEVEL
                        || s_sum_release >= {1'b0, MAX_LEVEL}) begin
                        n_level = MAX_LEVEL;
                    end else begin
                        n_level = s_sum_release[LEVEL_WIDTH-1:0];
                    end
                end
                default: begin
                    n_level = s_entry.level;
                end
            endcase
        end
    end

    // Next phase
    always_comb begin
        unique case (s_entry.phase)
            PH_ATTACK:  n_phase = s_phase_end ? PH_DECAY   : PH_ATTACK;
            PH_DECAY:   n_phase = s_phase_end ? PH_SUSTAIN : PH_DECAY;
            PH_RELEASE: n_phase = s_phase_end ? PH_DONE    : PH_RELEASE;
            PH_SUSTAIN: n_phase = PH_SUSTAIN;
            PH_DONE:    n_phase = PH_DONE;
            default:    n_phase = PH_DONE;
        endcase
    end

    // Collect the updated state
    always_comb begin
        o_state.phase = n_phase;
        o_state.count = s_phase_end ? '0 : s_count_step;
        o_state.level = n_level;
    end

endmodule

`default_nettype wire

// File: rtl/core/adsr_envelope_db.sv
// Top level of the centibel ADSR envelope: handshake pipeline and envelope state.
`default_nettype none

// ADSR volume envelope, one update per sample tick.
// Input channel (i_in_valid / o_in_ready / i_in): one transfer per sample tick,
// carrying note_on and note_off. Output channel (o_out_valid / i_out_ready /
// o_out): one result per tick, the attenuation in Q10.16 centibels after the
// update and the phase it ended in.
// Configuration: write i_cfg_data to register i_cfg_index with i_cfg_we high,
// only while no tick is in flight; there is no read-back.
// Path: a transferred tick lands in the input register; once the output register
// is free it is updated and loaded there, and its result is offered on o_out.
// Throughput is one tick per cycle while i_out_ready is high; the state update
// (one rate add and one bound compare on the level register) is combinational.
// Reset: envelope goes to done at 960 cB, configuration registers to zero, both
// pipeline stages empty.
// Stall: while i_out_ready is low the result holds; the input register still
// takes one more tick, then o_in_ready drops until the result is taken.
module adsr_envelope_db
    import adsr_db_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire t_in_item                   i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output t_out_item                       o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    t_cfg       s_cfg;
    t_env_state r_state;
    t_env_state n_state;
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       s_out_free;
    logic       s_advance;

    adsr_db_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (s_cfg)
    );

    adsr_db_step u_step (
        .i_cfg   (s_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state)
    );

    // Move the held tick forward whenever the output register can take it
    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_advance  = r_in_valid && s_out_free;
    assign o_in_ready = !r_in_valid || s_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Envelope state, updated once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_DONE;
            r_state.count <= '0;
            r_state.level <= MAX_LEVEL;
        end else if (s_advance) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_out.attenuation <= n_state.level;
            r_out.phase       <= 3'(n_state.phase);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The level never leaves the 0 .. 960 cB range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.level <= MAX_LEVEL)
        else $error("envelope level above full scale");

    // A result offered downstream carries a level in range
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.attenuation <= MAX_LEVEL)
        else $error("result attenuation above full scale");

    // State only changes when a tick moves to the output register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_advance |=> $stable(r_state))
        else $error("envelope state changed without a tick");

    // An empty input register always takes a transfer
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stalled while empty");

    // A transferred tick is held in the input register next cycle
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted tick lost");

endmodule

`default_nettype wire
